// ===== rtl/core/qsd_pkg.sv =====
// package for the quadrotor state derivative: payload types, constants, helpers
`default_nettype none
package qsd_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;
	localparam int XW                = 34;   // cordic x/y width, q2.30 with headroom
	localparam int ZW                = 33;   // cordic angle width, 2^31 = pi
	localparam int REG_W             = 24;
	localparam int IDX_W             = 2;

	localparam logic [XW-1:0] CORDIC_GAIN = XW'(32'h26DD3B6A);
	localparam logic signed [44:0] GRAVITY_Q16 = 45'sd642908;
	localparam logic [REG_W-1:0] REG_RESET = REG_W'(65536);

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_INV_MASS = 2'd0,
		REG_INV_IX   = 2'd1,
		REG_INV_IY   = 2'd2
	} reg_idx_t;

	typedef logic [ZW-1:0] atan_tab_t [ATAN_LEN];
	localparam atan_tab_t ATAN_TAB = '{
		33'h020000000, 33'h012E4051E, 33'h009FB385B, 33'h0051111D4, 33'h0028B0D43,
		33'h00145D7E1, 33'h000A2F61E, 33'h000517C55, 33'h00028BE53, 33'h000145F2F,
		33'h0000A2F98, 33'h0000517CC, 33'h000028BE6, 33'h0000145F3, 33'h00000A2FA,
		33'h00000517D, 33'h0000028BE, 33'h00000145F, 33'h000000A30, 33'h000000518,
		33'h00000028C, 33'h000000146, 33'h0000000A3, 33'h000000051
	};

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] rate_q;
		logic signed [31:0] rate_r;
		logic signed [31:0] thrust;
		logic signed [31:0] thrust_rate;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic signed [31:0] ctrl_thrust_accel;
		logic signed [31:0] ctrl_roll_torque;
		logic signed [31:0] ctrl_pitch_torque;
	} in_t;

	typedef struct packed {
		logic signed [31:0] dpos_x;
		logic signed [31:0] dpos_y;
		logic signed [31:0] dpos_z;
		logic signed [31:0] dpitch;
		logic signed [31:0] droll;
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [31:0] dthrust;
		logic signed [31:0] dthrust_rate;
		logic signed [31:0] drate_q;
		logic signed [31:0] drate_r;
	} out_t;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -48'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// fold a binary angle into [-pi/2, pi/2], wide angle 2^31 = pi
	function automatic logic [ZW:0] fold(input logic signed [15:0] ang);
		logic signed [16:0] a;
		logic neg;
		a = 17'(ang);
		neg = 1'b0;
		if (a > 17'sd16384) begin
			a = a - 17'sd32768;
			neg = 1'b1;
		end else if (a < -17'sd16384) begin
			a = a + 17'sd32768;
			neg = 1'b1;
		end
		return {neg, ZW'(a) << 16};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/quadrotor_state_derivative.sv =====
// quadrotor state derivative: cordic sin/cos pipeline and gain multipliers
//
//  channel | signals                        | handshake
//  --------+--------------------------------+-----------------------------------
//  input   | start, busy, in_item           | beat taken when start && !busy
//  result  | done, result                   | one-cycle strobe, no back-pressure
//  config  | wr_en, wr_index, wr_data       | write on any edge with wr_en high
//
// one item per clock; the pipeline is the angle fold, one register per cordic
// rotation, then three multiplier stages. busy stays low.
// reset clears valid bits and sets all three gain registers to 1.0.
// the result side cannot stall, so nothing in the pipe ever waits.
`default_nettype none
module quadrotor_state_derivative #(
	parameter int CORDIC_STAGES = qsd_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire qsd_pkg::in_t                  in_item,
	output logic                               done,
	output qsd_pkg::out_t                      result,
	input  wire logic                          wr_en,
	input  wire logic [qsd_pkg::IDX_W-1:0]     wr_index,
	input  wire logic [qsd_pkg::REG_W-1:0]     wr_data
);
	localparam int XW = qsd_pkg::XW;
	localparam int ZW = qsd_pkg::ZW;

	logic [qsd_pkg::REG_W-1:0] inv_mass_q, inv_ix_q, inv_iy_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= qsd_pkg::REG_RESET;
			inv_ix_q   <= qsd_pkg::REG_RESET;
			inv_iy_q   <= qsd_pkg::REG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				qsd_pkg::REG_INV_MASS: inv_mass_q <= wr_data;
				qsd_pkg::REG_INV_IX:   inv_ix_q   <= wr_data;
				qsd_pkg::REG_INV_IY:   inv_iy_q   <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic                 vld_s  [CORDIC_STAGES+1];
	qsd_pkg::in_t         item_s [CORDIC_STAGES+1];
	logic                 pneg_s [CORDIC_STAGES+1];
	logic                 rneg_s [CORDIC_STAGES+1];
	logic signed [XW-1:0] px_s   [CORDIC_STAGES+1];
	logic signed [XW-1:0] py_s   [CORDIC_STAGES+1];
	logic signed [ZW-1:0] pz_s   [CORDIC_STAGES+1];
	logic signed [XW-1:0] rx_s   [CORDIC_STAGES+1];
	logic signed [XW-1:0] ry_s   [CORDIC_STAGES+1];
	logic signed [ZW-1:0] rz_s   [CORDIC_STAGES+1];

	logic [ZW:0] pfold, rfold;
	assign pfold = qsd_pkg::fold(in_item.pitch_angle);
	assign rfold = qsd_pkg::fold(in_item.roll_angle);

	// entry stage: fold angles into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s[0] <= in_item;
		pneg_s[0] <= pfold[ZW];
		rneg_s[0] <= rfold[ZW];
		pz_s[0]   <= $signed(pfold[ZW-1:0]);
		rz_s[0]   <= $signed(rfold[ZW-1:0]);
		px_s[0]   <= $signed(qsd_pkg::CORDIC_GAIN);
		rx_s[0]   <= $signed(qsd_pkg::CORDIC_GAIN);
		py_s[0]   <= '0;
		ry_s[0]   <= '0;
	end

	// cordic rotation stages, one per register
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
		logic signed [XW-1:0] pxs, pys, rxs, rys;
		logic signed [ZW-1:0] at;
		assign pxs = px_s[k] >>> k;
		assign pys = py_s[k] >>> k;
		assign rxs = rx_s[k] >>> k;
		assign rys = ry_s[k] >>> k;
		assign at  = $signed(qsd_pkg::ATAN_TAB[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			item_s[k+1] <= item_s[k];
			pneg_s[k+1] <= pneg_s[k];
			rneg_s[k+1] <= rneg_s[k];
			if (!pz_s[k][ZW-1]) begin
				px_s[k+1] <= px_s[k] - pys;
				py_s[k+1] <= py_s[k] + pxs;
				pz_s[k+1] <= pz_s[k] - at;
			end else begin
				px_s[k+1] <= px_s[k] + pys;
				py_s[k+1] <= py_s[k] - pxs;
				pz_s[k+1] <= pz_s[k] + at;
			end
			if (!rz_s[k][ZW-1]) begin
				rx_s[k+1] <= rx_s[k] - rys;
				ry_s[k+1] <= ry_s[k] + rxs;
				rz_s[k+1] <= rz_s[k] - at;
			end else begin
				rx_s[k+1] <= rx_s[k] + rys;
				ry_s[k+1] <= ry_s[k] - rxs;
				rz_s[k+1] <= rz_s[k] + at;
			end
		end
	end

	// unfold: sine and cosine of pitch (t) and roll (p)
	logic signed [XW-1:0] st, ct, sp, cp;
	assign st = pneg_s[CORDIC_STAGES] ? -py_s[CORDIC_STAGES] : py_s[CORDIC_STAGES];
	assign ct = pneg_s[CORDIC_STAGES] ? -px_s[CORDIC_STAGES] : px_s[CORDIC_STAGES];
	assign sp = rneg_s[CORDIC_STAGES] ? -ry_s[CORDIC_STAGES] : ry_s[CORDIC_STAGES];
	assign cp = rneg_s[CORDIC_STAGES] ? -rx_s[CORDIC_STAGES] : rx_s[CORDIC_STAGES];

	logic signed [2*XW-1:0] tpx_w, tpz_w;
	logic signed [XW+24:0]  gy_w;
	logic signed [56:0]     tq_w, tr_w;
	assign tpx_w = st * cp;
	assign tpz_w = cp * ct;
	assign gy_w  = (-sp) * $signed({1'b0, inv_mass_q});
	assign tq_w  = item_s[CORDIC_STAGES].ctrl_roll_torque * $signed({1'b0, inv_ix_q});
	assign tr_w  = item_s[CORDIC_STAGES].ctrl_pitch_torque * $signed({1'b0, inv_iy_q});

	logic                 vld_s1, vld_s2;
	qsd_pkg::in_t         item_s1, item_s2;
	logic signed [XW-1:0] tpx_s1, tpz_s1;
	logic signed [27:0]   gy_s1, gy_s2;
	logic signed [31:0]   dq_s1, dr_s1, dq_s2, dr_s2;

	// first multiplier stage: trig products, mass gain on y, angular terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= vld_s[CORDIC_STAGES];
			vld_s2 <= vld_s1;
			done   <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_s[CORDIC_STAGES];
		tpx_s1  <= XW'(tpx_w >>> 30);
		tpz_s1  <= XW'(tpz_w >>> 30);
		gy_s1   <= 28'(gy_w >>> 30);
		dq_s1   <= qsd_pkg::sat32(48'(tq_w >>> 16));
		dr_s1   <= qsd_pkg::sat32(48'(tr_w >>> 16));
	end

	// second multiplier stage: mass gain on x and z
	logic signed [XW+24:0] gx_w, gz_w;
	logic signed [27:0]    gx_s2, gz_s2;
	assign gx_w = tpx_s1 * $signed({1'b0, inv_mass_q});
	assign gz_w = tpz_s1 * $signed({1'b0, inv_mass_q});

	always_ff @(posedge clk) begin
		item_s2 <= item_s1;
		gx_s2   <= 28'(gx_w >>> 30);
		gz_s2   <= 28'(gz_w >>> 30);
		gy_s2   <= gy_s1;
		dq_s2   <= dq_s1;
		dr_s2   <= dr_s1;
	end

	// third stage: thrust products, gravity, saturation into the result register
	logic signed [59:0] ax_w, ay_w, az_w;
	logic signed [44:0] az_g;
	assign ax_w = gx_s2 * item_s2.thrust;
	assign ay_w = gy_s2 * item_s2.thrust;
	assign az_w = gz_s2 * item_s2.thrust;
	assign az_g = 45'(az_w >>> 16) - qsd_pkg::GRAVITY_Q16;

	always_ff @(posedge clk) begin
		result.dpos_x       <= item_s2.vel_x;
		result.dpos_y       <= item_s2.vel_y;
		result.dpos_z       <= item_s2.vel_z;
		result.dpitch       <= item_s2.rate_q;
		result.droll        <= item_s2.rate_r;
		result.accel_x      <= qsd_pkg::sat32(48'(ax_w >>> 16));
		result.accel_y      <= qsd_pkg::sat32(48'(ay_w >>> 16));
		result.accel_z      <= qsd_pkg::sat32(48'(az_g));
		result.dthrust      <= item_s2.thrust_rate;
		result.dthrust_rate <= item_s2.ctrl_thrust_accel;
		result.drate_q      <= dq_s2;
		result.drate_r      <= dr_s2;
	end

endmodule
`default_nettype wire

// ===== tb/quadrotor_state_derivative_test.sv =====
// testbench for quadrotor_state_derivative: random and directed state vectors checked against a cordic predictor
`default_nettype none
module quadrotor_state_derivative_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES  = 16;
	localparam int LATENCY = STAGES + 4;
	localparam int N_RAND  = 1900;
	localparam logic signed [63:0] GRAV = 64'sd642908;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	qsd_pkg::in_t in_item;
	logic done;
	qsd_pkg::out_t result;
	logic wr_en;
	logic [qsd_pkg::IDX_W-1:0] wr_index;
	logic [qsd_pkg::REG_W-1:0] wr_data;

	logic [qsd_pkg::REG_W-1:0] gain_mass, gain_ix, gain_iy;
	qsd_pkg::in_t pending_items[$];
	qsd_pkg::out_t expected_derivs[$];
	int errors;
	bit no_idle;

	quadrotor_state_derivative #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// sine and cosine of a binary angle, q2.30
	task automatic trig(input logic signed [15:0] ang, output logic signed [63:0] s,
			output logic signed [63:0] c);
		logic signed [63:0] a, x, y, z, xs, ys, atan_i;
		logic flip;
		a = 64'(ang);
		flip = 1'b0;
		x = 64'sh26DD3B6A;
		y = 0;
		if (a > 16384) begin
			a = a - 32768;
			flip = 1'b1;
		end else if (a < -16384) begin
			a = a + 32768;
			flip = 1'b1;
		end
		z = a * 65536;
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			atan_i = 64'(qsd_pkg::ATAN_TAB[i]);
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - atan_i;
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + atan_i;
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// expected derivative for one state vector
	task automatic derive(input qsd_pkg::in_t it, output qsd_pkg::out_t d);
		logic signed [63:0] st, ct, sp, cp, im, gx, gy, gz, thr, ix, iy;
		trig(it.pitch_angle, st, ct);
		trig(it.roll_angle, sp, cp);
		im = 64'(gain_mass);
		ix = 64'(gain_ix);
		iy = 64'(gain_iy);
		thr = 64'(it.thrust);
		gx = (((st * cp) >>> 30) * im) >>> 30;
		gy = ((-sp) * im) >>> 30;
		gz = (((cp * ct) >>> 30) * im) >>> 30;
		d.dpos_x = it.vel_x;
		d.dpos_y = it.vel_y;
		d.dpos_z = it.vel_z;
		d.dpitch = it.rate_q;
		d.droll = it.rate_r;
		d.accel_x = clamp32((gx * thr) >>> 16);
		d.accel_y = clamp32((gy * thr) >>> 16);
		d.accel_z = clamp32(((gz * thr) >>> 16) - GRAV);
		d.dthrust = it.thrust_rate;
		d.dthrust_rate = it.ctrl_thrust_accel;
		d.drate_q = clamp32((64'(it.ctrl_roll_torque) * ix) >>> 16);
		d.drate_r = clamp32((64'(it.ctrl_pitch_torque) * iy) >>> 16);
	endtask

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rnd_angle();
		case ($urandom_range(0, 7))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($urandom_range(16383, 16385));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic qsd_pkg::in_t rnd_item();
		qsd_pkg::in_t it;
		it.vel_x = rnd32();
		it.vel_y = rnd32();
		it.vel_z = rnd32();
		it.rate_q = rnd32();
		it.rate_r = rnd32();
		it.thrust = rnd32();
		it.thrust_rate = rnd32();
		it.pitch_angle = rnd_angle();
		it.roll_angle = rnd_angle();
		it.ctrl_thrust_accel = rnd32();
		it.ctrl_roll_torque = rnd32();
		it.ctrl_pitch_torque = rnd32();
		return it;
	endfunction

	// driver: one beat per accepted start, random idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			in_item <= '0;
		end else begin
			if (start && !busy) begin
				void'(pending_items.pop_front());
			end
			if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= 28)) begin
				start <= 1'b1;
				in_item <= pending_items[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// prediction at acceptance
	always @(posedge clk) begin
		qsd_pkg::out_t d;
		if (arst_n && start && !busy) begin
			derive(in_item, d);
			expected_derivs.push_back(d);
		end
	end

	// monitor
	always @(posedge clk) begin
		qsd_pkg::out_t e;
		if (arst_n && done) begin
			if (expected_derivs.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				errors++;
			end else begin
				e = expected_derivs.pop_front();
				if (e !== result) begin
					$display("%0t: mismatch expected %h actual %h", $time, e, result);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input qsd_pkg::reg_idx_t idx,
			input logic [qsd_pkg::REG_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			qsd_pkg::REG_INV_MASS: gain_mass = val;
			qsd_pkg::REG_INV_IX:   gain_ix = val;
			default:               gain_iy = val;
		endcase
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !start);
		wait (expected_derivs.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// stimulus
	initial begin
		qsd_pkg::in_t it;
		logic [qsd_pkg::REG_W-1:0] settings[5][3];
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		errors = 0;
		no_idle = 0;
		gain_mass = qsd_pkg::REG_RESET;
		gain_ix = qsd_pkg::REG_RESET;
		gain_iy = qsd_pkg::REG_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at reset gains
		it = '0;
		pending_items.push_back(it);
		it = '1;
		pending_items.push_back(it);
		for (int k = 0; k < 12; k++) begin
			it = rnd_item();
			it.thrust = (k % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
			it.pitch_angle = (k < 6) ? 16'sd16384 : -16'sd16384;
			it.roll_angle = 16'(k * 5461 - 32768);
			it.ctrl_roll_torque = (k % 3 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
			pending_items.push_back(it);
		end
		it = rnd_item();
		it.pitch_angle = 16'h8000;
		it.roll_angle = 16'sd16385;
		pending_items.push_back(it);
		it.pitch_angle = 16'sd0;
		it.roll_angle = -16'sd16385;
		pending_items.push_back(it);
		it.pitch_angle = 16'h7FFF;
		it.roll_angle = 16'sd0;
		pending_items.push_back(it);
		drain();

		// gain settings: extremes and random
		settings[0] = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		settings[1] = '{24'h0, 24'h0, 24'h0};
		settings[2] = '{24'h000001, 24'hFFFFFF, 24'h010000};
		settings[3] = '{24'($urandom), 24'($urandom), 24'($urandom)};
		settings[4] = '{24'(32'h8000 + $urandom_range(0, 32'h20000)),
			24'($urandom_range(0, 32'h40000)), 24'($urandom_range(0, 32'h40000))};
		for (int p = 0; p < 5; p++) begin
			write_reg(qsd_pkg::REG_INV_MASS, settings[p][0]);
			write_reg(qsd_pkg::REG_INV_IX, settings[p][1]);
			write_reg(qsd_pkg::REG_INV_IY, settings[p][2]);
			no_idle = (p == 3);
			for (int n = 0; n < N_RAND / 5; n++) begin
				pending_items.push_back(rnd_item());
			end
			drain();
		end
		if (errors == 0) begin
			$display("quadrotor_state_derivative regression: pass");
		end else begin
			$display("quadrotor_state_derivative regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("quadrotor_state_derivative regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
